// File: rtl/zs_pkg.sv
// zs_pkg: widths, register indexes and helpers shared by the rolling z-score core
// no dependencies; imported by every module of the block
package zs_pkg;

	localparam int MAX_WINDOW = 256;
	localparam int PRICE_BITS = 24;
	localparam int WL_BITS    = 9;
	localparam int SLOT_BITS  = 8;
	localparam int Z_BITS     = 24;
	localparam int SUM_BITS   = 32;
	localparam int SQ_BITS    = 56;
	localparam int PROD_BITS  = 76;
	localparam int MPL_BITS   = 33;
	localparam int NUM_BITS   = 74;
	localparam int QUO_BITS   = 46;
	localparam int ROOT_BITS  = 23;
	localparam int CIDX_BITS  = 2;

	// register indexes of the configuration port
	localparam logic [CIDX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
	localparam logic [CIDX_BITS-1:0] REG_ENTRY_THRESH  = 2'd1;
	localparam logic [CIDX_BITS-1:0] REG_EXIT_THRESH   = 2'd2;

	localparam logic [WL_BITS-1:0] WL_RESET    = 9'd20;
	localparam logic [Z_BITS-1:0]  ENTRY_RESET = 24'd131072;
	localparam logic [Z_BITS-1:0]  EXIT_RESET  = 24'd32768;
	localparam logic [Z_BITS-1:0]  Z_POS_SAT   = 24'h7FFFFF;
	localparam logic [Z_BITS-1:0]  Z_NEG_SAT   = 24'h800000;

	// window length in force: zero acts as one, above the store size acts as its size
	function automatic logic [WL_BITS-1:0] eff_length(input logic [WL_BITS-1:0] wl);
		logic [WL_BITS-1:0] n;
		if (wl == '0)
			n = WL_BITS'(1);
		else if (wl > WL_BITS'(MAX_WINDOW))
			n = WL_BITS'(MAX_WINDOW);
		else
			n = wl;
		return n;
	endfunction

endpackage

// File: rtl/zs_mul.sv
// zs_mul: shift-add serial multiplier, one multiplier bit per cycle
// depends on zs_pkg
module zs_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [zs_pkg::PROD_BITS-1:0]  mcand,
	input  logic [zs_pkg::MPL_BITS-1:0]   mplier,
	output logic                          done,
	output logic [zs_pkg::PROD_BITS-1:0]  product
);
	import zs_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [PROD_BITS-1:0]  acc_q;
	logic [PROD_BITS-1:0]  mc_q;
	logic [MPL_BITS-1:0]   mp_q;

	// control: finish once the remaining multiplier bits are gone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (mp_q[MPL_BITS-1:1] == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath: add shifted multiplicand when the low multiplier bit is set
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= mcand;
			mp_q  <= mplier;
		end else if (busy_q) begin
			if (mp_q[0])
				acc_q <= acc_q + mc_q;
			mc_q <= mc_q << 1;
			mp_q <= mp_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// File: rtl/zs_div.sv
// zs_div: restoring divider, one quotient bit per cycle, with saturation check
// depends on zs_pkg; quotient of num * 2^32 / den, saturating at 2^46
module zs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [zs_pkg::NUM_BITS-1:0]   num,
	input  logic [zs_pkg::NUM_BITS-1:0]   den,
	output logic                          done,
	output logic                          sat,
	output logic [zs_pkg::QUO_BITS-1:0]   quo
);
	import zs_pkg::*;

	// dividend bits below the first quotient bit that come from num itself
	localparam int LOW_BITS = QUO_BITS - 32;

	logic                  busy_q;
	logic                  done_q;
	logic                  sat_q;
	logic [5:0]            cnt_q;
	logic [NUM_BITS-1:0]   rem_q;
	logic [QUO_BITS-1:0]   sh_q;
	logic [QUO_BITS-1:0]   quo_q;
	logic                  over;
	logic [NUM_BITS:0]     trial;
	logic [NUM_BITS:0]     den_x;

	// quotient would reach 2^46 exactly when num >= den * 2^14
	assign over  = {LOW_BITS'(0), num} >= {den, LOW_BITS'(0)};
	assign trial = {rem_q, sh_q[QUO_BITS-1]};
	assign den_x = {1'b0, den};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !over;
				done_q <= over;
				cnt_q  <= 6'(QUO_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift in one dividend bit, subtract where it fits
	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= over;
			rem_q <= {LOW_BITS'(0), num[NUM_BITS-1:LOW_BITS]};
			sh_q  <= {num[LOW_BITS-1:0], 32'd0};
			quo_q <= '0;
		end else if (busy_q) begin
			sh_q <= sh_q << 1;
			if (trial >= den_x) begin
				rem_q <= NUM_BITS'(trial - den_x);
				quo_q <= {quo_q[QUO_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial[NUM_BITS-1:0];
				quo_q <= {quo_q[QUO_BITS-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign sat  = sat_q;
	assign quo  = quo_q;

endmodule

// File: rtl/zs_sqrt.sv
// zs_sqrt: digit-by-digit integer square root, one root bit per cycle
// depends on zs_pkg
module zs_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [zs_pkg::QUO_BITS-1:0]   value,
	output logic                          done,
	output logic [zs_pkg::ROOT_BITS-1:0]  root
);
	import zs_pkg::*;

	localparam int REM_BITS = ROOT_BITS + 2;
	localparam int T_BITS   = REM_BITS + 2;

	logic                  busy_q;
	logic                  done_q;
	logic [4:0]            cnt_q;
	logic [QUO_BITS-1:0]   v_q;
	logic [REM_BITS-1:0]   rem_q;
	logic [ROOT_BITS-1:0]  root_q;
	logic [T_BITS-1:0]     t;
	logic [T_BITS-1:0]     trial;

	assign t     = {rem_q, v_q[QUO_BITS-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(ROOT_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: bring down two bits, try 4*root+1
	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q <= v_q << 2;
			if (t >= trial) begin
				rem_q  <= REM_BITS'(t - trial);
				root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= t[REM_BITS-1:0];
				root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: rtl/rolling_zscore_signal_core.sv
// rolling_zscore_signal_core: rolling z-score of mid-price samples with enter/exit flags
// depends on zs_pkg, zs_mul, zs_div, zs_sqrt
//
// Usage:
//  - input channel in_valid/in_ready/mid_price: one request per sample; a zero
//    price leaves the window untouched but still yields one result
//  - output channel out_valid/out_ready: z_score (signed Q8.16), enter_long,
//    exit_position, window_full, one result per input request
//  - config channel cfg_valid/cfg_ready/cfg_index/cfg_data, always ready:
//    0 window length (empties the window), 1 entry threshold, 2 exit threshold
//  - one request at a time; in_ready is high only when the core is idle. Once
//    the window is full a request uses the shared serial multiplier (one bit per
//    cycle, up to eight products), the serial divider and the serial square root;
//    the next request can be taken in the cycle after loading
//  - a finished result sits in the output register; while the receiver stalls
//    the core holds in its final state and takes no new request
//  - reset empties the window and loads length 20, thresholds 2.0 and 0.5;
//    the sample store itself is not cleared (stale entries are never used)
module rolling_zscore_signal_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [zs_pkg::PRICE_BITS-1:0]     mid_price,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [zs_pkg::Z_BITS-1:0]  z_score,
	output logic                              enter_long,
	output logic                              exit_position,
	output logic                              window_full,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [zs_pkg::CIDX_BITS-1:0]      cfg_index,
	input  logic [zs_pkg::Z_BITS-1:0]         cfg_data
);
	import zs_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQX  = 4'd1;
	localparam logic [3:0] ST_SQO  = 4'd2;
	localparam logic [3:0] ST_UPD  = 4'd3;
	localparam logic [3:0] ST_ZCHK = 4'd4;
	localparam logic [3:0] ST_S2   = 4'd5;
	localparam logic [3:0] ST_NQ   = 4'd6;
	localparam logic [3:0] ST_NX   = 4'd7;
	localparam logic [3:0] ST_AA   = 4'd8;
	localparam logic [3:0] ST_PN   = 4'd9;
	localparam logic [3:0] ST_DEN  = 4'd10;
	localparam logic [3:0] ST_DIV  = 4'd11;
	localparam logic [3:0] ST_SQRT = 4'd12;
	localparam logic [3:0] ST_FIN  = 4'd13;

	logic [3:0]            state_q;
	logic                  launched_q;
	logic [WL_BITS-1:0]    wl_q;
	logic [Z_BITS-1:0]     entry_q;
	logic [Z_BITS-1:0]     exit_q;
	logic [WL_BITS-1:0]    cnt_q;
	logic [SLOT_BITS-1:0]  slot_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic [SQ_BITS-1:0]    sq_q;
	logic [PRICE_BITS-1:0] newest_q;
	logic [PRICE_BITS-1:0] x_q;
	logic [PRICE_BITS-1:0] old_q;
	logic                  drop_q;
	logic [63:0]           s2_q;
	logic [64:0]           d_q;
	logic                  neg_q;
	logic [MPL_BITS-1:0]   a_q;
	logic [65:0]           aa_q;
	logic [NUM_BITS-1:0]   p_q;
	logic [NUM_BITS-1:0]   den_q;
	logic [Z_BITS-1:0]     z_q;
	logic                  out_valid_q;
	logic [Z_BITS-1:0]     z_out_q;
	logic                  enter_q;
	logic                  exitp_q;
	logic                  full_q;

	logic [PRICE_BITS-1:0] mem_q [MAX_WINDOW];

	logic [WL_BITS-1:0]    n;
	logic [SLOT_BITS-1:0]  slot_fix;
	logic [WL_BITS-1:0]    slot_inc;
	logic [PRICE_BITS-1:0] x_in;
	logic                  in_acc;
	logic                  cfg_acc;
	logic                  is_mul;
	logic                  mul_start;
	logic                  div_start;
	logic                  sqrt_start;
	logic                  mul_done;
	logic                  div_done;
	logic                  div_sat;
	logic                  sqrt_done;
	logic [PROD_BITS-1:0]  mcand;
	logic [MPL_BITS-1:0]   mplier;
	logic [PROD_BITS-1:0]  prod;
	logic [QUO_BITS-1:0]   quo;
	logic [ROOT_BITS-1:0]  root;
	logic [64:0]           nq;
	logic [MPL_BITS-1:0]   nx;
	logic [MPL_BITS-1:0]   sum_x;
	logic [Z_BITS-1:0]     z_root;
	logic [Z_BITS:0]       abs_z;
	logic                  out_load;

	assign n         = eff_length(wl_q);
	assign x_in      = mid_price[PRICE_BITS-1:0];
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign slot_fix  = ({1'b0, slot_q} >= n) ? '0 : slot_q;
	assign slot_inc  = {1'b0, slot_q} + WL_BITS'(1);
	assign nq        = prod[64:0];
	assign nx        = prod[MPL_BITS-1:0];
	assign sum_x     = {1'b0, sum_q};
	assign z_root    = neg_q ? Z_BITS'(-{1'b0, root}) : {1'b0, root};
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// unit launches: one start pulse on entry to each arithmetic state
	assign is_mul = (state_q == ST_SQX) || (state_q == ST_SQO) || (state_q == ST_S2)
		|| (state_q == ST_NQ) || (state_q == ST_NX) || (state_q == ST_AA)
		|| (state_q == ST_PN) || (state_q == ST_DEN);
	assign mul_start  = is_mul && !launched_q;
	assign div_start  = (state_q == ST_DIV) && !launched_q;
	assign sqrt_start = (state_q == ST_SQRT) && !launched_q;

	// multiplier operand selection
	always_comb begin
		mcand  = '0;
		mplier = '0;
		unique case (state_q)
			ST_SQX: begin
				mcand  = PROD_BITS'(x_q);
				mplier = MPL_BITS'(x_q);
			end
			ST_SQO: begin
				mcand  = PROD_BITS'(old_q);
				mplier = MPL_BITS'(old_q);
			end
			ST_S2: begin
				mcand  = PROD_BITS'(sum_q);
				mplier = MPL_BITS'(sum_q);
			end
			ST_NQ: begin
				mcand  = PROD_BITS'(sq_q);
				mplier = MPL_BITS'(n);
			end
			ST_NX: begin
				mcand  = PROD_BITS'(newest_q);
				mplier = MPL_BITS'(n);
			end
			ST_AA: begin
				mcand  = PROD_BITS'(a_q);
				mplier = a_q;
			end
			ST_PN: begin
				mcand  = PROD_BITS'(aa_q);
				mplier = MPL_BITS'(n - WL_BITS'(1));
			end
			ST_DEN: begin
				mcand  = PROD_BITS'(d_q);
				mplier = MPL_BITS'(n);
			end
			default: begin
				mcand  = '0;
				mplier = '0;
			end
		endcase
	end

	zs_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mcand),
		.mplier  (mplier),
		.done    (mul_done),
		.product (prod)
	);

	zs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (p_q),
		.den    (den_q),
		.done   (div_done),
		.sat    (div_sat),
		.quo    (quo)
	);

	zs_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (quo),
		.done   (sqrt_done),
		.root   (root)
	);

	// sample store: oldest sample read on request, new sample written on update
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD)
			mem_q[slot_q] <= x_q;
		if (in_acc && (x_in != '0))
			old_q <= mem_q[slot_fix];
	end

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			launched_q <= 1'b0;
			wl_q       <= WL_RESET;
			entry_q    <= ENTRY_RESET;
			exit_q     <= EXIT_RESET;
			cnt_q      <= '0;
			slot_q     <= '0;
			sum_q      <= '0;
			sq_q       <= '0;
			newest_q   <= '0;
		end else begin
			if (mul_start || div_start || sqrt_start)
				launched_q <= 1'b1;
			else if (mul_done || div_done || sqrt_done)
				launched_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (x_in != '0) begin
							slot_q  <= slot_fix;
							state_q <= ST_SQX;
						end else begin
							state_q <= ST_ZCHK;
						end
					end
				end
				ST_SQX: begin
					if (mul_done) begin
						sq_q    <= sq_q + prod[SQ_BITS-1:0];
						state_q <= drop_q ? ST_SQO : ST_UPD;
					end
				end
				ST_SQO: begin
					if (mul_done) begin
						sq_q    <= sq_q - prod[SQ_BITS-1:0];
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					sum_q    <= sum_q + SUM_BITS'(x_q) - (drop_q ? SUM_BITS'(old_q) : '0);
					newest_q <= x_q;
					if (!drop_q)
						cnt_q <= cnt_q + WL_BITS'(1);
					slot_q  <= (slot_inc >= n) ? '0 : slot_inc[SLOT_BITS-1:0];
					state_q <= ST_ZCHK;
				end
				ST_ZCHK: begin
					state_q <= ((cnt_q < n) || (n < WL_BITS'(2))) ? ST_FIN : ST_S2;
				end
				ST_S2: begin
					if (mul_done)
						state_q <= ST_NQ;
				end
				ST_NQ: begin
					if (mul_done)
						state_q <= (nq <= {1'b0, s2_q}) ? ST_FIN : ST_NX;
				end
				ST_NX: begin
					if (mul_done)
						state_q <= ST_AA;
				end
				ST_AA: begin
					if (mul_done)
						state_q <= ST_PN;
				end
				ST_PN: begin
					if (mul_done)
						state_q <= ST_DEN;
				end
				ST_DEN: begin
					if (mul_done)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= div_sat ? ST_FIN : ST_SQRT;
				end
				ST_SQRT: begin
					if (sqrt_done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// configuration writes; a new length empties the window
			if (cfg_acc) begin
				unique case (cfg_index)
					REG_WINDOW_LENGTH: begin
						wl_q   <= cfg_data[WL_BITS-1:0];
						cnt_q  <= '0;
						slot_q <= '0;
						sum_q  <= '0;
						sq_q   <= '0;
					end
					REG_ENTRY_THRESH: entry_q <= cfg_data;
					REG_EXIT_THRESH:  exit_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// intermediate products and the z value
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q    <= x_in;
			drop_q <= (cnt_q >= n);
		end
		if (state_q == ST_ZCHK)
			z_q <= '0;
		if (mul_done) begin
			unique case (state_q)
				ST_S2:  s2_q <= prod[63:0];
				ST_NQ: begin
					d_q <= nq - {1'b0, s2_q};
				end
				ST_NX: begin
					neg_q <= nx < sum_x;
					a_q   <= (nx < sum_x) ? (sum_x - nx) : (nx - sum_x);
				end
				ST_AA:  aa_q  <= prod[65:0];
				ST_PN:  p_q   <= prod[NUM_BITS-1:0];
				ST_DEN: den_q <= prod[NUM_BITS-1:0];
				default: ;
			endcase
		end
		if ((state_q == ST_DIV) && div_done && div_sat)
			z_q <= neg_q ? Z_NEG_SAT : Z_POS_SAT;
		if ((state_q == ST_SQRT) && sqrt_done)
			z_q <= z_root;
	end

	// flags from the final z value
	assign abs_z = z_q[Z_BITS-1] ? (Z_BITS+1)'(-{z_q[Z_BITS-1], z_q}) : {1'b0, z_q};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			z_out_q <= z_q;
			enter_q <= $signed(z_q) > $signed(entry_q);
			exitp_q <= $signed(abs_z) < $signed({exit_q[Z_BITS-1], exit_q});
			full_q  <= (cnt_q >= n);
		end
	end

	assign out_valid     = out_valid_q;
	assign z_score       = z_out_q;
	assign enter_long    = enter_q;
	assign exit_position = exitp_q;
	assign window_full   = full_q;

`ifndef NO_ASSERTIONS
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != ST_IDLE))
		else $error("core stayed idle after accepting a request");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (cnt_q <= n))
		else $error("sample count beyond window length");

	a_mul_done_in_mul_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> is_mul)
		else $error("multiplier finished outside a multiply state");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && (state_q == ST_FIN)) |=> (state_q == ST_FIN))
		else $error("result dropped while receiver stalled");
`endif

endmodule

// File: sim/rolling_zscore_signal_core_test.sv
// rolling_zscore_signal_core_test: self-checking testbench for the rolling z-score core
// depends on zs_pkg and rolling_zscore_signal_core; predicts every result in place
module rolling_zscore_signal_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import zs_pkg::*;

	// an index that names no register
	localparam logic [CIDX_BITS-1:0] REG_NONE = 2'd3;
	localparam int RING_DEPTH = 8;

	typedef struct packed {
		logic signed [Z_BITS-1:0] z;
		logic                     enter;
		logic                     leave;
		logic                     full;
	} zs_result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [PRICE_BITS-1:0]     mid_price;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [Z_BITS-1:0]  z_score;
	logic                      enter_long;
	logic                      exit_position;
	logic                      window_full;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CIDX_BITS-1:0]      cfg_index;
	logic [Z_BITS-1:0]         cfg_data;

	// predictor state
	logic [WL_BITS-1:0]    length_reg;
	logic [Z_BITS-1:0]     entry_reg;
	logic [Z_BITS-1:0]     leave_reg;
	logic [PRICE_BITS-1:0] price_store [MAX_WINDOW];
	int unsigned           held_count;
	int unsigned           next_slot;
	logic [63:0]           price_sum;
	logic [63:0]           square_sum;
	logic [PRICE_BITS-1:0] latest_price;

	// predicted results waiting for the core, oldest at ring_rd
	zs_result_t  want_ring [RING_DEPTH];
	logic [2:0]  ring_wr;
	logic [2:0]  ring_rd;
	int          ring_fill;

	int          mismatches;
	int          sender_idle_pct;
	int          receiver_stall_pct;
	logic [23:0] base_price;
	logic [23:0] last_price;

	rolling_zscore_signal_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .mid_price(mid_price),
		.out_valid(out_valid), .out_ready(out_ready), .z_score(z_score),
		.enter_long(enter_long), .exit_position(exit_position), .window_full(window_full),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// guard against a hang
	initial begin
		#10ms;
		$display("[rolling_zscore_signal_core] ERROR");
		$finish;
	end

	function automatic int unsigned window_in_force();
		if (length_reg == '0)
			return 1;
		if (length_reg > MAX_WINDOW)
			return MAX_WINDOW;
		return length_reg;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bitv;
		root = '0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// z of the newest sample, truncated and saturated
	function automatic longint window_z();
		logic [127:0] n;
		logic [127:0] s2;
		logic [127:0] nq;
		logic [127:0] dev;
		logic [127:0] nx;
		logic [127:0] diff;
		logic [127:0] quot;
		logic         neg;
		longint       mag;
		n = window_in_force();
		if (held_count < n || n < 2)
			return 0;
		s2 = 128'(price_sum) * 128'(price_sum);
		nq = n * 128'(square_sum);
		if (nq <= s2)
			return 0;
		dev = nq - s2;
		nx = n * 128'(latest_price);
		neg = nx < 128'(price_sum);
		diff = neg ? 128'(price_sum) - nx : nx - 128'(price_sum);
		quot = ((diff * diff * (n - 1)) << 32) / (n * dev);
		if (quot >= (128'd1 << 46))
			return neg ? -8388608 : 8388607;
		mag = longint'(int_sqrt(quot[63:0]));
		return neg ? -mag : mag;
	endfunction

	// advance the predictor by one accepted sample and queue its result
	function automatic void predict_sample(input logic [PRICE_BITS-1:0] px);
		int unsigned n;
		logic [63:0] old;
		longint      z;
		longint      absz;
		zs_result_t  r;
		n = window_in_force();
		if (px != 0) begin
			if (next_slot >= n)
				next_slot = 0;
			if (held_count >= n) begin
				old = 64'(price_store[next_slot]);
				price_sum = price_sum - old;
				square_sum = square_sum - old * old;
			end else begin
				held_count++;
			end
			price_store[next_slot] = px;
			price_sum = price_sum + 64'(px);
			square_sum = square_sum + 64'(px) * 64'(px);
			next_slot++;
			if (next_slot >= n)
				next_slot = 0;
			latest_price = px;
		end
		z = window_z();
		absz = z < 0 ? -z : z;
		r.z = z[Z_BITS-1:0];
		r.enter = z > longint'($signed(entry_reg));
		r.leave = absz < longint'($signed(leave_reg));
		r.full = held_count >= n;
		want_ring[ring_wr] = r;
		ring_wr = ring_wr + 3'd1;
		ring_fill++;
	endfunction

	// one sample request
	task automatic send_price(input logic [PRICE_BITS-1:0] px);
		logic took;
		if ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			mid_price <= PRICE_BITS'($urandom);
			@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		mid_price <= px;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		predict_sample(px);
	endtask

	// register write, once every result is out and the core is idle
	task automatic write_reg(input logic [CIDX_BITS-1:0] idx, input logic [Z_BITS-1:0] val);
		logic took;
		in_valid <= 1'b0;
		while (ring_fill != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		cfg_valid <= 1'b0;
		case (idx)
			REG_WINDOW_LENGTH: begin
				length_reg = val[WL_BITS-1:0];
				held_count = 0;
				next_slot = 0;
				price_sum = '0;
				square_sum = '0;
			end
			REG_ENTRY_THRESH: entry_reg = val;
			REG_EXIT_THRESH: leave_reg = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// let every outstanding result drain, then settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (ring_fill != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [23:0] pick_price();
		int sel;
		sel = $urandom_range(99);
		if (sel < 10)
			return 24'd0;
		if (sel < 35)
			last_price = 24'($urandom);
		else if (sel < 45)
			last_price = last_price == 0 ? base_price : last_price;
		else
			last_price = base_price + 24'($urandom_range(255)) - 24'd128;
		return last_price;
	endfunction

	// receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= $urandom_range(99) >= receiver_stall_pct;
	end

	// result check, sampled away from the active edge
	always @(negedge clk) begin
		zs_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (ring_fill == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result z=%0d", z_score);
			end else begin
				want = want_ring[ring_rd];
				ring_rd = ring_rd + 3'd1;
				ring_fill--;
				if (z_score !== want.z || enter_long !== want.enter
						|| exit_position !== want.leave || window_full !== want.full) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected z=%0d en=%b ex=%b full=%b, got z=%0d en=%b ex=%b full=%b",
							want.z, want.enter, want.leave, want.full,
							z_score, enter_long, exit_position, window_full);
				end
			end
		end
	end

	// extremes of price and thresholds, zero price, defaults, unusual lengths and an unused index
	task automatic test_directed();
		int i;
		send_price(24'd0);
		for (i = 0; i < 12; i++)
			send_price(i[0] ? 24'hFFFFFF : 24'd1);
		send_price(24'd0);
		write_reg(REG_WINDOW_LENGTH, 24'd0);
		send_price(24'd77);
		send_price(24'd78);
		write_reg(REG_WINDOW_LENGTH, 24'd1);
		send_price(24'd5);
		write_reg(REG_WINDOW_LENGTH, 24'hFFFE02);
		send_price(24'd100);
		send_price(24'd100);
		send_price(24'd100);
		send_price(24'd200);
		write_reg(REG_ENTRY_THRESH, 24'h800000);
		write_reg(REG_EXIT_THRESH, 24'h7FFFFF);
		write_reg(REG_NONE, 24'h123456);
		send_price(24'd150);
		send_price(24'd0);
		write_reg(REG_ENTRY_THRESH, 24'h7FFFFF);
		write_reg(REG_EXIT_THRESH, 24'h800000);
		send_price(24'd10);
		send_price(24'd0);
		wait_drained();
	endtask

	// a long window filled past its largest size
	task automatic test_full_store();
		int i;
		write_reg(REG_WINDOW_LENGTH, 24'd511);
		write_reg(REG_ENTRY_THRESH, 24'd65536);
		write_reg(REG_EXIT_THRESH, 24'd65536);
		base_price = 24'($urandom);
		for (i = 0; i < 290; i++)
			send_price(i == 270 ? 24'hFFFFFF : pick_price());
		wait_drained();
	endtask

	// random windows, thresholds and prices under one idling pattern
	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
		int i;
		int sel;
		logic [8:0] lens [8];
		lens = '{9'd2, 9'd3, 9'd4, 9'd5, 9'd8, 9'd13, 9'd1, 9'd0};
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		for (i = 0; i < count; i++) begin
			if (i % 60 == 0) begin
				wait_drained();
				sel = $urandom_range(7);
				write_reg(REG_WINDOW_LENGTH, 24'(lens[sel]) | (24'($urandom) & 24'hFFFE00));
				write_reg(REG_ENTRY_THRESH, $urandom_range(9) == 0 ? 24'($urandom)
					: 24'($signed(24'($urandom_range(262144))) - 24'sd65536));
				write_reg(REG_EXIT_THRESH, $urandom_range(9) == 0 ? 24'($urandom)
					: 24'($urandom_range(131072)));
				base_price = 24'($urandom);
			end
			send_price(pick_price());
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mid_price = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		base_price = 24'd1000;
		last_price = 24'd1000;
		length_reg = WL_RESET;
		entry_reg = ENTRY_RESET;
		leave_reg = EXIT_RESET;
		held_count = 0;
		next_slot = 0;
		price_sum = '0;
		square_sum = '0;
		latest_price = '0;
		ring_wr = '0;
		ring_rd = '0;
		ring_fill = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_store();
		test_random_phase(0, 0, 200);
		test_random_phase(66, 0, 200);
		test_random_phase(0, 66, 200);
		test_random_phase(29, 29, 200);
		test_random_phase(0, 0, 30);

		if (mismatches == 0 && ring_fill == 0)
			$display("[rolling_zscore_signal_core] OK");
		else
			$display("[rolling_zscore_signal_core] ERROR");
		$finish;
	end

endmodule

// File: sim.f
rtl/zs_pkg.sv
rtl/zs_mul.sv
rtl/zs_div.sv
rtl/zs_sqrt.sv
rtl/rolling_zscore_signal_core.sv
sim/rolling_zscore_signal_core_test.sv
